// ===== hw/rtl/lfol_pkg.sv =====
// Shared types, constants and helpers for the limited first-order lag.
// Used by lfol_ctrl, lfol_datapath and the limited_first_order_lag top level.
package lfol_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_TIME_CONST = 2'd0;
  localparam logic [1:0] REG_UPPER      = 2'd1;
  localparam logic [1:0] REG_LOWER      = 2'd2;

  // Item kinds
  localparam logic [1:0] FUNC_INIT    = 2'd0;
  localparam logic [1:0] FUNC_PREDICT = 2'd1;
  localparam logic [1:0] FUNC_CORRECT = 2'd2;

  typedef struct packed {
    logic        en;
    logic [1:0]  idx;
    logic [31:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [30:0] time_constant;
    logic [31:0] upper_limit;
    logic [31:0] lower_limit;
  } cfg_rd_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic load;
    logic prep;
    logic div_step;
    logic slope;
    logic rate;
    logic mul_lo;
    logic mul_hi;
    logic round;
    logic fin;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] func;
    logic       bypass;
  } status_t;

  // Upper limit first, then lower
  function automatic logic signed [31:0] clamp_lim(input logic signed [31:0] x,
                                                   input logic signed [31:0] up,
                                                   input logic signed [31:0] lo);
    logic signed [31:0] r;
    r = (x > up) ? up : x;
    r = (r < lo) ? lo : r;
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    logic signed [31:0] r;
    if (v > 65'sd2147483647) r = 32'sh7fffffff;
    else if (v < -65'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== hw/rtl/lfol_ctrl.sv =====
// Sequencer for the lag: steps one request through load and, for predict and
// correct, divide, multiply, round and commit. Depends on lfol_pkg.
module lfol_ctrl import lfol_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_fire,
  input  logic    out_free,
  input  status_t stat,
  output logic    in_ready,
  output cmd_t    cmd
);

  localparam int DW = 33 + FRAC_BITS;
  localparam int CW = $clog2(DW + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_PREP  = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_SLOPE = 4'd4;
  localparam logic [3:0] S_RATE  = 4'd5;
  localparam logic [3:0] S_MUL0  = 4'd6;
  localparam logic [3:0] S_MUL1  = 4'd7;
  localparam logic [3:0] S_ROUND = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.capture = in_fire;
        if (in_fire) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.load = 1'b1;
        if (stat.func == FUNC_PREDICT || stat.func == FUNC_CORRECT) state_nxt = S_PREP;
        else state_nxt = S_DONE;
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        cnt_nxt  = CW'(DW - 1);
        state_nxt = stat.bypass ? S_SLOPE : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = S_SLOPE;
      end
      S_SLOPE: begin
        cmd.slope = 1'b1;
        state_nxt = S_RATE;
      end
      S_RATE: begin
        cmd.rate = 1'b1;
        state_nxt = S_MUL0;
      end
      S_MUL0: begin
        cmd.mul_lo = 1'b1;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_hi = 1'b1;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // Hold until the output register is free
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/lfol_datapath.sv =====
// Datapath of the lag: configuration and state registers, bit-serial
// divider, split multiplier, rounding and saturation. Depends on lfol_pkg.
module lfol_datapath import lfol_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_wr_t     cfg_wr,
  output cfg_rd_t     cfg_rd,
  input  cmd_t        cmd,
  output status_t     stat,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_val,
  input  logic [30:0] in_step,
  input  logic        in_rep,
  output logic [31:0] res_value
);

  localparam int DW = 33 + FRAC_BITS;
  localparam logic signed [32:0] TENTH = 33'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

  // Configuration and persistent state
  logic [30:0]        tc_r;
  logic signed [31:0] ul_r, ll_r, ue_r, le_r;
  logic signed [31:0] sn_r, snx_r, sl_r;

  // Per-request registers
  logic [1:0]         func_r;
  logic signed [31:0] u_r, y_r, s_r, base_r;
  logic [30:0]        h_r;
  logic               rep_r, bypass_r, neg_r, dneg_r;
  logic [DW-1:0]      num_r;
  logic [31:0]        rem_r;
  logic [32:0]        mag_r;
  logic [63:0]        acc_r, p_r;

  logic signed [31:0] sel_y, y_now;
  logic               byp_now;
  logic signed [32:0] diff, rate;
  logic [32:0]        dmag, rem2;
  logic [30:0]        qsat;
  logic signed [31:0] s_now;
  logic signed [64:0] sum;
  logic signed [32:0] up_w, lo_w;

  assign cfg_rd    = '{time_constant: tc_r, upper_limit: ul_r, lower_limit: ll_r};
  assign stat      = '{func: func_r, bypass: bypass_r};
  assign res_value = y_r;

  // Load-stage selection of the operating point
  always_comb begin
    byp_now = (tc_r == '0) || ({2'b00, tc_r} < {h_r, 2'b00});
    case (func_r)
      FUNC_PREDICT: sel_y = byp_now ? u_r : (rep_r ? sn_r : snx_r);
      FUNC_CORRECT: sel_y = byp_now ? u_r : snx_r;
      default:      sel_y = sn_r;
    endcase
    y_now = (func_r == FUNC_INIT) ? u_r : clamp_lim(sel_y, ue_r, le_r);
    up_w  = {u_r[31], u_r} + TENTH;
    lo_w  = {u_r[31], u_r} - TENTH;
  end

  // Divider step, slope shaping, rate and final sum
  always_comb begin
    diff = {u_r[31], u_r} - {y_r[31], y_r};
    dmag = diff[32] ? 33'(-diff) : 33'(diff);
    rem2 = {rem_r, num_r[DW-1]};
    qsat = (|num_r[DW-1:31]) ? 31'h7fffffff : num_r[30:0];
    s_now = dneg_r ? -$signed({1'b0, qsat}) : $signed({1'b0, qsat});
    if (s_now > 0 && y_r >= ue_r) s_now = '0;
    if (s_now < 0 && y_r <= le_r) s_now = '0;
    rate = (func_r == FUNC_CORRECT) ? ({sl_r[31], sl_r} + {s_r[31], s_r})
                                    : {s_r[31], s_r};
    sum = neg_r ? ({{33{base_r[31]}}, base_r} - $signed({1'b0, p_r}))
                : ({{33{base_r[31]}}, base_r} + $signed({1'b0, p_r}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r  <= 31'h10000;
      ul_r  <= 32'sh10000;
      ll_r  <= -32'sh10000;
      ue_r  <= 32'sh10000;
      le_r  <= -32'sh10000;
      sn_r  <= '0;
      snx_r <= '0;
      sl_r  <= '0;
    end else begin
      // Limit register writes also reset the effective limits
      if (cfg_wr.en) begin
        case (cfg_wr.idx)
          REG_TIME_CONST: tc_r <= cfg_wr.data[30:0];
          REG_UPPER: begin
            ul_r <= cfg_wr.data;
            ue_r <= cfg_wr.data;
          end
          REG_LOWER: begin
            ll_r <= cfg_wr.data;
            le_r <= cfg_wr.data;
          end
          default: ;
        endcase
      end
      // Initialize: load state and widen limits
      if (cmd.load && func_r == FUNC_INIT) begin
        sn_r  <= u_r;
        snx_r <= u_r;
        sl_r  <= '0;
        ue_r  <= (u_r > ul_r) ? sat32(65'(up_w)) : ul_r;
        le_r  <= (u_r < ll_r) ? sat32(65'(lo_w)) : ll_r;
      end
      // Commit the step
      if (cmd.fin) begin
        snx_r <= sat32(sum);
        if (func_r == FUNC_PREDICT) begin
          sn_r <= y_r;
          sl_r <= s_r;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_func;
      u_r    <= in_val;
      h_r    <= in_step;
      rep_r  <= in_rep;
    end
    if (cmd.load) begin
      y_r      <= y_now;
      bypass_r <= byp_now;
    end
    if (cmd.prep) begin
      dneg_r <= diff[32];
      rem_r  <= '0;
      num_r  <= bypass_r ? '0 : (DW'(dmag) << FRAC_BITS);
    end
    // Restoring divide, quotient shifts in at the bottom
    if (cmd.div_step) begin
      if (rem2 >= {2'b00, tc_r}) begin
        rem_r <= 32'(rem2 - {2'b00, tc_r});
        num_r <= {num_r[DW-2:0], 1'b1};
      end else begin
        rem_r <= rem2[31:0];
        num_r <= {num_r[DW-2:0], 1'b0};
      end
    end
    if (cmd.slope) s_r <= s_now;
    if (cmd.rate) begin
      neg_r  <= rate[32];
      mag_r  <= rate[32] ? 33'(-rate) : 33'(rate);
      base_r <= (func_r == FUNC_CORRECT) ? sn_r : y_r;
    end
    // Product in two halves, operands widened to the full product width
    if (cmd.mul_lo) acc_r <= {48'd0, mag_r[15:0]} * {33'd0, h_r};
    if (cmd.mul_hi) acc_r <= acc_r + (({47'd0, mag_r[32:16]} * {33'd0, h_r}) << 16);
    if (cmd.round) begin
      if (func_r == FUNC_CORRECT)
        p_r <= (acc_r + (64'd1 << FRAC_BITS)) >> (FRAC_BITS + 1);
      else
        p_r <= (acc_r + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    end
  end

endmodule

// ===== hw/rtl/limited_first_order_lag.sv =====
// Limited first-order lag, Heun integration in fixed point.
// Init and unused kinds go from load straight to the result; predict and
// correct also run the one-bit-a-cycle slope divider, then multiply, round
// and commit. Bypass skips the divider.
// One request at a time; a new request is taken while a result waits.
// Synchronous active-low reset restores register defaults and zero state.
module limited_first_order_lag import lfol_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_value[31:0], step_size[62:32], repeat_predict[63]
  input  logic [63:0] in_tdata,
  // func[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_value[31:0]
  output logic [31:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cmd_t        cmd;
  status_t     stat;
  cfg_wr_t     cfg_wr;
  cfg_rd_t     cfg_rd;
  logic        in_fire, out_free;
  logic [31:0] res_value;
  logic        out_valid_r;
  logic [31:0] out_data_r;

  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Decode register writes and reads
  assign cfg_pready = 1'b1;
  assign cfg_wr = '{en: cfg_psel && cfg_penable && cfg_pwrite,
                    idx: cfg_paddr[3:2], data: cfg_pwdata};
  always_comb begin
    case (cfg_paddr[3:2])
      REG_TIME_CONST: cfg_prdata = {1'b0, cfg_rd.time_constant};
      REG_UPPER:      cfg_prdata = cfg_rd.upper_limit;
      REG_LOWER:      cfg_prdata = cfg_rd.lower_limit;
      default:        cfg_prdata = '0;
    endcase
  end

  lfol_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .stat     (stat),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  lfol_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .cfg_rd    (cfg_rd),
    .cmd       (cmd),
    .stat      (stat),
    .in_func   (in_tuser),
    .in_val    (in_tdata[31:0]),
    .in_step   (in_tdata[62:32]),
    .in_rep    (in_tdata[63]),
    .res_value (res_value)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) out_data_r <= res_value;
  end

endmodule
